// File: hw/rtl/lrs_pkg.sv
package lrs_pkg;

  localparam int COORD_INT_BITS_DEF  = 12;
  localparam int COORD_FRAC_BITS_DEF = 4;

  localparam int ROW_W  = 13;
  localparam int SPAN_W = 13;
  // quotient bits resolved by the divider; results at or above 2**QB saturate
  localparam int QB     = 13;
  localparam int QSW    = QB + 2;
  localparam int LAT    = QB + 6;

  localparam logic [SPAN_W-1:0] SPAN_MAX = '1;

  typedef enum logic [1:0] {
    CFG_FIRST_X  = 2'd0,
    CFG_FIRST_Y  = 2'd1,
    CFG_SECOND_X = 2'd2,
    CFG_SECOND_Y = 2'd3
  } lrs_cfg_idx_e;

  typedef struct packed {
    logic valid;
    logic cov;
  } lrs_tag_t;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  function automatic int w_coord(input int ib, input int fb);
    return ib + fb;
  endfunction

  function automatic int w_rnd(input int ib);
    return ib + 1;
  endfunction

  function automatic int w_off(input int ib, input int fb);
    return imax(ROW_W + 1 + fb, ib + fb + 1) + 2;
  endfunction

  function automatic int w_prod(input int ib, input int fb);
    return w_off(ib, fb) + ib + fb + 1;
  endfunction

  function automatic int w_base(input int ib, input int fb);
    return 2 * (ib + fb) + 1;
  endfunction

  function automatic int w_num(input int ib, input int fb);
    return imax(w_base(ib, fb), w_prod(ib, fb)) + 2;
  endfunction

  function automatic int w_den(input int ib, input int fb);
    return ib + 2 * fb + 1;
  endfunction

  function automatic int w_rem(input int ib, input int fb);
    return imax(w_num(ib, fb) - 1, w_den(ib, fb) + QB) + 1;
  endfunction

  function automatic int w_ext(input int ib);
    return imax(QSW, ib + 2);
  endfunction

endpackage

// File: hw/rtl/lrs_cfg.sv
module lrs_cfg #(
  parameter int COORD_INT_BITS  = lrs_pkg::COORD_INT_BITS_DEF,
  parameter int COORD_FRAC_BITS = lrs_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  lrs_pkg::lrs_cfg_idx_e    cfg_index_i,
  input  logic [lrs_pkg::w_coord(COORD_INT_BITS, COORD_FRAC_BITS)-1:0] cfg_data_i,
  output logic [lrs_pkg::w_coord(COORD_INT_BITS, COORD_FRAC_BITS)-1:0] ly_o,
  output logic [lrs_pkg::w_coord(COORD_INT_BITS, COORD_FRAC_BITS)-1:0] dy_o,
  output logic signed [lrs_pkg::w_coord(COORD_INT_BITS, COORD_FRAC_BITS):0] dx_o,
  output logic [lrs_pkg::w_base(COORD_INT_BITS, COORD_FRAC_BITS)-1:0] base_o,
  output logic [lrs_pkg::w_den(COORD_INT_BITS, COORD_FRAC_BITS)-1:0] den_o,
  output logic [lrs_pkg::w_rnd(COORD_INT_BITS)-1:0] row_lo_o,
  output logic [lrs_pkg::w_rnd(COORD_INT_BITS)-1:0] row_hi_o,
  output logic [lrs_pkg::w_rnd(COORD_INT_BITS)-1:0] xa_lo_o,
  output logic [lrs_pkg::w_rnd(COORD_INT_BITS)-1:0] xa_hi_o,
  output logic                     horiz_o,
  output logic                     steep_o,
  output logic                     neg_o
);
  import lrs_pkg::*;

  localparam int CB   = w_coord(COORD_INT_BITS, COORD_FRAC_BITS);
  localparam int RW   = w_rnd(COORD_INT_BITS);
  localparam int BW   = w_base(COORD_INT_BITS, COORD_FRAC_BITS);
  localparam int DW   = w_den(COORD_INT_BITS, COORD_FRAC_BITS);
  localparam int HALF_UNIT = (1 << COORD_FRAC_BITS) >> 1;

  logic [CB-1:0] first_x_q, first_y_q, second_x_q, second_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_x_q  <= '0;
      first_y_q  <= '0;
      second_x_q <= '0;
      second_y_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FIRST_X:  first_x_q  <= cfg_data_i;
        CFG_FIRST_Y:  first_y_q  <= cfg_data_i;
        CFG_SECOND_X: second_x_q <= cfg_data_i;
        CFG_SECOND_Y: second_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [CB-1:0]        lx, ly, hx, hy, min_x, max_x;
  logic [CB-1:0]        dy_d;
  logic signed [CB:0]   dx_d;
  logic [CB:0]          adx;
  logic [2*CB-1:0]      prod;
  logic [BW-1:0]        base_d;
  logic [DW-1:0]        den_d;
  logic [RW-1:0]        row_lo_d, row_hi_d, xa_lo_d, xa_hi_d;

  always_comb begin
    if (first_y_q <= second_y_q) begin
      lx = first_x_q;  ly = first_y_q;  hx = second_x_q; hy = second_y_q;
    end else begin
      lx = second_x_q; ly = second_y_q; hx = first_x_q;  hy = first_y_q;
    end
    min_x = (first_x_q <= second_x_q) ? first_x_q : second_x_q;
    max_x = (first_x_q >= second_x_q) ? first_x_q : second_x_q;
    xa_lo_d  = RW'(({1'b0, min_x} + (CB+1)'(HALF_UNIT)) >> COORD_FRAC_BITS);
    xa_hi_d  = RW'(({1'b0, max_x} + (CB+1)'(HALF_UNIT)) >> COORD_FRAC_BITS);
    row_lo_d = RW'(({1'b0, ly} + (CB+1)'(HALF_UNIT)) >> COORD_FRAC_BITS);
    row_hi_d = RW'(({1'b0, hy} + (CB+1)'(HALF_UNIT)) >> COORD_FRAC_BITS);
    dy_d     = hy - ly;
    dx_d     = $signed({1'b0, hx}) - $signed({1'b0, lx});
    adx      = dx_d[CB] ? (CB+1)'(-dx_d) : (CB+1)'(dx_d);
    prod     = (2*CB)'(lx) * (2*CB)'(dy_d);
    base_d   = {prod, 1'b0};
    den_d    = DW'(dy_d) << (COORD_FRAC_BITS + 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ly_o     <= '0;
      dy_o     <= '0;
      dx_o     <= '0;
      base_o   <= '0;
      den_o    <= '0;
      row_lo_o <= '0;
      row_hi_o <= '0;
      xa_lo_o  <= '0;
      xa_hi_o  <= '0;
      horiz_o  <= 1'b1;
      steep_o  <= 1'b1;
      neg_o    <= 1'b0;
    end else begin
      ly_o     <= ly;
      dy_o     <= dy_d;
      dx_o     <= dx_d;
      base_o   <= base_d;
      den_o    <= den_d;
      row_lo_o <= row_lo_d;
      row_hi_o <= row_hi_d;
      xa_lo_o  <= xa_lo_d;
      xa_hi_o  <= xa_hi_d;
      horiz_o  <= (dy_d == '0);
      steep_o  <= (adx <= {1'b0, dy_d});
      neg_o    <= dx_d[CB];
    end
  end

endmodule

// File: hw/rtl/lrs_num.sv
module lrs_num #(
  parameter int COORD_INT_BITS  = lrs_pkg::COORD_INT_BITS_DEF,
  parameter int COORD_FRAC_BITS = lrs_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic [lrs_pkg::ROW_W-1:0] row_i,
  input  logic [lrs_pkg::w_coord(COORD_INT_BITS, COORD_FRAC_BITS)-1:0] ly_i,
  input  logic [lrs_pkg::w_coord(COORD_INT_BITS, COORD_FRAC_BITS)-1:0] dy_i,
  input  logic signed [lrs_pkg::w_coord(COORD_INT_BITS, COORD_FRAC_BITS):0] dx_i,
  input  logic [lrs_pkg::w_base(COORD_INT_BITS, COORD_FRAC_BITS)-1:0] base_i,
  input  logic [lrs_pkg::w_den(COORD_INT_BITS, COORD_FRAC_BITS)-1:0] den_i,
  input  logic [lrs_pkg::w_rnd(COORD_INT_BITS)-1:0] row_lo_i,
  input  logic [lrs_pkg::w_rnd(COORD_INT_BITS)-1:0] row_hi_i,
  input  logic                     steep_i,
  output lrs_pkg::lrs_tag_t        tag_o,
  output logic signed [lrs_pkg::w_num(COORD_INT_BITS, COORD_FRAC_BITS)-1:0] na_o,
  output logic signed [lrs_pkg::w_num(COORD_INT_BITS, COORD_FRAC_BITS)-1:0] nb_o
);
  import lrs_pkg::*;

  localparam int RW = w_rnd(COORD_INT_BITS);
  localparam int OW = w_off(COORD_INT_BITS, COORD_FRAC_BITS);
  localparam int PW = w_prod(COORD_INT_BITS, COORD_FRAC_BITS);
  localparam int NW = w_num(COORD_INT_BITS, COORD_FRAC_BITS);
  localparam int CW = imax(ROW_W, RW);
  localparam logic signed [OW-1:0] ONE_O = OW'(1 << COORD_FRAC_BITS);
  localparam logic signed [NW-1:0] ONE_N = NW'(1);

  // stage 1: row
  logic             v1_q;
  logic [ROW_W-1:0] r1_q;
  // stage 2: offset from lower endpoint in doubled units
  logic             v2_q, c2_q;
  logic signed [OW-1:0] off2_q;
  // stage 3: products
  logic             v3_q, c3_q;
  logic signed [PW-1:0] pa3_q, pb3_q;

  logic                 cov_d;
  logic signed [OW-1:0] off_d, ma, mb;
  logic signed [PW-1:0] pa_d, pb_d;
  logic signed [NW-1:0] bse, adj_a, adj_b, na_d, nb_d;

  always_comb begin
    cov_d = (CW'(r1_q) >= CW'(row_lo_i)) && (CW'(r1_q) <= CW'(row_hi_i));
    off_d = $signed(OW'(r1_q) << (COORD_FRAC_BITS + 1)) - $signed(OW'(ly_i) << 1);
    ma    = steep_i ? off2_q : off2_q - ONE_O;
    mb    = off2_q + ONE_O;
    pa_d  = PW'(ma) * PW'(dx_i);
    pb_d  = PW'(mb) * PW'(dx_i);
    bse   = $signed(NW'(base_i));
    adj_b = $signed(NW'(den_i)) - ONE_N;
    adj_a = steep_i ? $signed(NW'(dy_i) << COORD_FRAC_BITS) : adj_b;
    na_d  = bse + NW'(pa3_q) + adj_a;
    nb_d  = bse + NW'(pb3_q) + adj_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      tag_o <= '0;
    end else begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      tag_o.valid <= v3_q;
      tag_o.cov   <= c3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r1_q   <= row_i;
    c2_q   <= cov_d;
    off2_q <= off_d;
    c3_q   <= c2_q;
    pa3_q  <= pa_d;
    pb3_q  <= pb_d;
    na_o   <= na_d;
    nb_o   <= nb_d;
  end

endmodule

// File: hw/rtl/lrs_div.sv
module lrs_div #(
  parameter int COORD_INT_BITS  = lrs_pkg::COORD_INT_BITS_DEF,
  parameter int COORD_FRAC_BITS = lrs_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lrs_pkg::lrs_tag_t        tag_i,
  input  logic signed [lrs_pkg::w_num(COORD_INT_BITS, COORD_FRAC_BITS)-1:0] na_i,
  input  logic signed [lrs_pkg::w_num(COORD_INT_BITS, COORD_FRAC_BITS)-1:0] nb_i,
  input  logic [lrs_pkg::w_den(COORD_INT_BITS, COORD_FRAC_BITS)-1:0] den_i,
  output lrs_pkg::lrs_tag_t        tag_o,
  output logic signed [lrs_pkg::QSW-1:0] qa_o,
  output logic signed [lrs_pkg::QSW-1:0] qb_o
);
  import lrs_pkg::*;

  localparam int NW = w_num(COORD_INT_BITS, COORD_FRAC_BITS);
  localparam int WW = w_rem(COORD_INT_BITS, COORD_FRAC_BITS);

  // floor division, result clamped to [-1, 2**QB]; one quotient bit per stage
  lrs_tag_t       tag_q  [QB+1];
  logic [WW-1:0]  rem_q  [QB+1][2];
  logic [QB-1:0]  quo_q  [QB+1][2];
  logic           neg_q  [QB+1][2];
  logic           over_q [QB+1][2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= QB; s++) tag_q[s] <= '0;
    end else begin
      tag_q[0] <= tag_i;
      for (int s = 1; s <= QB; s++) tag_q[s] <= tag_q[s-1];
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic signed [NW-1:0] n;
    logic [WW-1:0]        mag;
    assign n   = (l == 0) ? na_i : nb_i;
    assign mag = WW'(n[NW-2:0]);

    always_ff @(posedge clk_i) begin
      rem_q[0][l]  <= mag;
      quo_q[0][l]  <= '0;
      neg_q[0][l]  <= n[NW-1];
      over_q[0][l] <= !n[NW-1] && (mag >= (WW'(den_i) << QB));
    end

    for (genvar j = 1; j <= QB; j++) begin : g_step
      logic [WW-1:0] dk;
      logic          ge;
      assign dk = WW'(den_i) << (QB - j);
      assign ge = rem_q[j-1][l] >= dk;

      always_ff @(posedge clk_i) begin
        rem_q[j][l]  <= ge ? rem_q[j-1][l] - dk : rem_q[j-1][l];
        quo_q[j][l]  <= quo_q[j-1][l] | (ge ? (QB'(1) << (QB - j)) : '0);
        neg_q[j][l]  <= neg_q[j-1][l];
        over_q[j][l] <= over_q[j-1][l];
      end
    end
  end

  function automatic logic signed [QSW-1:0] pick(input logic neg, input logic over,
                                                 input logic [QB-1:0] quo);
    logic signed [QSW-1:0] r;
    if (neg)       r = '1;
    else if (over) r = QSW'(1) << QB;
    else           r = $signed({2'b00, quo});
    return r;
  endfunction

  assign tag_o = tag_q[QB];
  assign qa_o  = pick(neg_q[QB][0], over_q[QB][0], quo_q[QB][0]);
  assign qb_o  = pick(neg_q[QB][1], over_q[QB][1], quo_q[QB][1]);

endmodule

// File: hw/rtl/line_row_span_unit.sv
// Row span query for one line segment.
// Configuration: write first_x, first_y, second_x, second_y (indexes 0..3)
// on cfg_valid_i/cfg_index_i/cfg_data_i; cfg_ready_o is always high. The user
// must make writes while no rows are in flight and before the next row is started;
// the unit does not enforce this. Request: drive row_i with start high; busy
// stays low, so a new row is taken every cycle.
// Result: done_o pulses for one cycle with covered_o, span_start_o and
// span_end_o after the row passes the stages below, in request order. Rows out
// of the line's range give covered_o low and a zero span.
// Throughput is one row per cycle; latency is set by the 13-stage restoring
// divider (one quotient bit per stage) plus the row, offset, multiply, sum
// and divider setup stages ahead of it and the clamp stage behind it.
// The receiver cannot stall: each result is presented exactly once.
// Reset clears the coordinates to zero and drops all rows in flight.
module line_row_span_unit #(
  parameter int COORD_INT_BITS  = lrs_pkg::COORD_INT_BITS_DEF,
  parameter int COORD_FRAC_BITS = lrs_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [lrs_pkg::ROW_W-1:0] row_i,
  output logic                      done_o,
  output logic                      covered_o,
  output logic [lrs_pkg::SPAN_W-1:0] span_start_o,
  output logic [lrs_pkg::SPAN_W-1:0] span_end_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [1:0]                cfg_index_i,
  input  logic [lrs_pkg::w_coord(COORD_INT_BITS, COORD_FRAC_BITS)-1:0] cfg_data_i
);
  import lrs_pkg::*;

  localparam int CB = w_coord(COORD_INT_BITS, COORD_FRAC_BITS);
  localparam int RW = w_rnd(COORD_INT_BITS);
  localparam int BW = w_base(COORD_INT_BITS, COORD_FRAC_BITS);
  localparam int DW = w_den(COORD_INT_BITS, COORD_FRAC_BITS);
  localparam int NW = w_num(COORD_INT_BITS, COORD_FRAC_BITS);
  localparam int EW = w_ext(COORD_INT_BITS);
  localparam logic signed [EW-1:0] ONE_E = EW'(1);
  localparam logic signed [EW-1:0] MAX_E = EW'(SPAN_MAX);

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  logic [CB-1:0]        ly, dy;
  logic signed [CB:0]   dx;
  logic [BW-1:0]        base;
  logic [DW-1:0]        den;
  logic [RW-1:0]        row_lo, row_hi, xa_lo, xa_hi;
  logic                 horiz, steep, neg;

  lrs_cfg #(
    .COORD_INT_BITS (COORD_INT_BITS),
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i(lrs_cfg_idx_e'(cfg_index_i)),
    .cfg_data_i (cfg_data_i),
    .ly_o       (ly),
    .dy_o       (dy),
    .dx_o       (dx),
    .base_o     (base),
    .den_o      (den),
    .row_lo_o   (row_lo),
    .row_hi_o   (row_hi),
    .xa_lo_o    (xa_lo),
    .xa_hi_o    (xa_hi),
    .horiz_o    (horiz),
    .steep_o    (steep),
    .neg_o      (neg)
  );

  lrs_tag_t             num_tag, div_tag;
  logic signed [NW-1:0] na, nb;
  logic signed [QSW-1:0] qa, qb;

  lrs_num #(
    .COORD_INT_BITS (COORD_INT_BITS),
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_num (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(start && !busy),
    .row_i     (row_i),
    .ly_i      (ly),
    .dy_i      (dy),
    .dx_i      (dx),
    .base_i    (base),
    .den_i     (den),
    .row_lo_i  (row_lo),
    .row_hi_i  (row_hi),
    .steep_i   (steep),
    .tag_o     (num_tag),
    .na_o      (na),
    .nb_o      (nb)
  );

  lrs_div #(
    .COORD_INT_BITS (COORD_INT_BITS),
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .tag_i (num_tag),
    .na_i  (na),
    .nb_i  (nb),
    .den_i (den),
    .tag_o (div_tag),
    .qa_o  (qa),
    .qb_o  (qb)
  );

  function automatic logic [SPAN_W-1:0] sat(input logic signed [EW-1:0] v);
    logic [SPAN_W-1:0] r;
    if (v < 0)          r = '0;
    else if (v > MAX_E) r = SPAN_MAX;
    else                r = v[SPAN_W-1:0];
    return r;
  endfunction

  logic signed [EW-1:0] qa_e, hb_e, xl, xh, lo, hi;

  always_comb begin
    qa_e = EW'(qa);
    hb_e = EW'(qb) - ONE_E;
    xl   = $signed(EW'(xa_lo));
    xh   = $signed(EW'(xa_hi));
    lo   = xl;
    hi   = xh;
    if (horiz) begin
      lo = xl;
      hi = xh;
    end else if (steep) begin
      lo = qa_e;
      hi = qa_e;
    end else if (!neg) begin
      lo = (qa_e < xl) ? xl : qa_e;
      hi = (hb_e > xh) ? xh : hb_e;
    end else begin
      // falling shallow line: the raw span is inverted
      lo = (hb_e < xl) ? xl : hb_e;
      hi = (lo > xh) ? xh : lo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= div_tag.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    covered_o    <= div_tag.cov;
    span_start_o <= div_tag.cov ? sat(lo) : '0;
    span_end_o   <= div_tag.cov ? sat(hi) : '0;
  end

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##LAT done_o)
    else $error("row result missing at fixed latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LAT))
    else $error("result without a matching row");

  a_uncovered_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !covered_o |-> span_start_o == '0 && span_end_o == '0)
    else $error("uncovered row with nonzero span");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import lrs_pkg::*;

  localparam int CB = 16;
  localparam int FB = 4;
  localparam longint UNIT = 1 << FB;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic              covered;
    logic [SPAN_W-1:0] span_start;
    logic [SPAN_W-1:0] span_end;
  } span_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [ROW_W-1:0] row_i = '0;
  logic done_o, covered_o, cfg_ready_o;
  logic [SPAN_W-1:0] span_start_o, span_end_o;
  logic cfg_valid_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [CB-1:0] cfg_data_i = '0;

  logic [CB-1:0] ln_ax, ln_ay, ln_bx, ln_by;
  span_t span_q[$];
  int errors = 0;
  int rows_sent = 0;
  int spans_seen = 0;
  int lines_tried = 0;
  int idle_pct = 37;
  int quiet_cycles = 0;

  line_row_span_unit DUT (
    .clk_i, .rst_ni, .start, .busy, .row_i, .done_o, .covered_o,
    .span_start_o, .span_end_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint fdiv(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint cdiv(longint n, longint d);
    return -fdiv(-n, d);
  endfunction

  function automatic longint rnd(longint v);
    return fdiv(2 * v + UNIT, 2 * UNIT);
  endfunction

  function automatic logic [SPAN_W-1:0] sat(longint v);
    if (v < 0) return '0;
    if (v > 8191) return SPAN_MAX;
    return v[SPAN_W-1:0];
  endfunction

  function automatic span_t row_span(logic [ROW_W-1:0] row);
    longint r, ax, ay, bx, by, lx, ly, hx, hy, xlo, xhi, dx, dy, lo, hi;
    longint den, base, off, adx;
    span_t s;
    r = row; ax = ln_ax; ay = ln_ay; bx = ln_bx; by = ln_by;
    if (ay <= by) begin
      lx = ax; ly = ay; hx = bx; hy = by;
    end else begin
      lx = bx; ly = by; hx = ax; hy = ay;
    end
    xlo = rnd(ax <= bx ? ax : bx);
    xhi = rnd(ax >= bx ? ax : bx);
    dy = hy - ly;
    dx = hx - lx;
    s = '{1'b0, '0, '0};
    if (r < rnd(ly) || r > rnd(hy)) return s;
    if (dy == 0) begin
      lo = xlo; hi = xhi;
    end else begin
      den = 2 * dy * UNIT;
      base = 2 * lx * dy;
      off = 2 * r * UNIT - 2 * ly;
      adx = dx < 0 ? -dx : dx;
      if (adx <= dy) begin
        lo = fdiv(base + off * dx + dy * UNIT, den);
        hi = lo;
      end else begin
        lo = cdiv(base + (off - UNIT) * dx, den);
        hi = cdiv(base + (off + UNIT) * dx, den) - 1;
        if (lo <= hi) begin
          if (lo < xlo) lo = xlo;
          if (hi > xhi) hi = xhi;
        end else begin
          lo = (hi < xlo) ? xlo : hi;
          hi = (lo > xhi) ? xhi : lo;
        end
      end
    end
    s.covered = 1'b1;
    s.span_start = sat(lo);
    s.span_end = sat(hi);
    return s;
  endfunction

  always @(posedge clk_i) begin
    span_t e;
    if (done_o) begin
      spans_seen++;
      if (span_q.size() == 0) begin
        $error("result with no item pending");
        errors++;
      end else begin
        e = span_q.pop_front();
        if (covered_o !== e.covered) begin
          $error("covered: expected %0d actual %0d", e.covered, covered_o);
          errors++;
        end
        if (span_start_o !== e.span_start) begin
          $error("span_start: expected %0d actual %0d", e.span_start, span_start_o);
          errors++;
        end
        if (span_end_o !== e.span_end) begin
          $error("span_end: expected %0d actual %0d", e.span_end, span_end_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_row(logic [ROW_W-1:0] row);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    row_i <= row;
    do @(posedge clk_i); while (busy);
    span_q.push_back(row_span(row));
    rows_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (span_q.size() != 0) @(posedge clk_i);
    repeat (LAT + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(lrs_cfg_idx_e idx, logic [CB-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_FIRST_X:  ln_ax = val;
      CFG_FIRST_Y:  ln_ay = val;
      CFG_SECOND_X: ln_bx = val;
      default:      ln_by = val;
    endcase
  endtask

  task automatic set_line(logic [CB-1:0] ax, logic [CB-1:0] ay,
                          logic [CB-1:0] bx, logic [CB-1:0] by);
    drain();
    write_reg(CFG_FIRST_X, ax);
    write_reg(CFG_FIRST_Y, ay);
    write_reg(CFG_SECOND_X, bx);
    write_reg(CFG_SECOND_Y, by);
    cfg_valid_i <= 1'b0;
    lines_tried++;
  endtask

  task automatic test_directed();
    send_row(0);
    send_row(1);
    set_line(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
    send_row(0); send_row(4096); send_row(4095); send_row(13'h1FFF); send_row(2048);
    set_line(16'h0108, 16'h0208, 16'h0F37, 16'h0208);
    send_row(31); send_row(32); send_row(33);
    set_line(16'hFFFF, 16'h0018, 16'h0000, 16'h0038);
    send_row(1); send_row(2); send_row(3); send_row(4);
    set_line(16'h0500, 16'hFFFF, 16'h0508, 16'h0000);
    send_row(0); send_row(4096); send_row(1000);
    set_line(16'h0018, 16'h0100, 16'h0F08, 16'h0100);
    send_row(16); send_row(15); send_row(17);
  endtask

  task automatic test_random_lines();
    logic [CB-1:0] ax, ay, bx, by;
    int ry_lo, ry_hi, n;
    for (int k = 0; k < 70; k++) begin
      ax = CB'($urandom); bx = CB'($urandom); ay = CB'($urandom);
      case ($urandom_range(3))
        0: by = ay;
        1: by = CB'(ay + $urandom_range(255));
        2: by = CB'(ay - $urandom_range(64));
        default: by = CB'($urandom);
      endcase
      if (k % 5 == 0) begin
        ax = ay; bx = CB'(ax + $urandom_range(40) - 20);
      end
      set_line(ax, ay, bx, by);
      idle_pct = (k >= 30 && k < 40) ? 0 : 37;
      ry_lo = (ay < by ? ay : by) >> FB;
      ry_hi = (ay < by ? by : ay) >> FB;
      n = 0;
      while (n < 10) begin
        if ($urandom_range(9) < 8)
          send_row(ROW_W'(ry_lo + $urandom_range(ry_hi - ry_lo + 1)));
        else
          send_row(ROW_W'($urandom));
        n++;
      end
    end
    idle_pct = 37;
  endtask

  initial begin
    ln_ax = '0; ln_ay = '0; ln_bx = '0; ln_by = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_lines();
    drain();
    $display("Sent %0d rows over %0d line settings, %0d spans checked",
             rows_sent, lines_tried, spans_seen);
    if (errors == 0 && span_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/lrs_pkg.sv
hw/rtl/lrs_cfg.sv
hw/rtl/lrs_num.sv
hw/rtl/lrs_div.sv
hw/rtl/line_row_span_unit.sv
sim/tb_top.sv
